// ===== design/mdst_pkg.sv =====
// Package: shared types, codes and constants of the multidrop serial slave transfer core.
package mdst_pkg;

  // Header layout: address low/high, length low/high, command and block
  localparam int HDR_BYTES  = 5;
  localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
  localparam int HDR_CMD    = HDR_BYTES - 1;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_CODE    = 2'd2;

  // Register reset values
  localparam logic [7:0] NODE_ADDRESS_RST = 8'd1;
  localparam logic [3:0] SEND_CODE_RST    = 4'd1;
  localparam logic [3:0] RECV_CODE_RST    = 4'd2;

  // Receive acknowledge is good when the byte sum lands on this value
  localparam logic [7:0] GOOD_SUM = 8'd55;

  // Input item operations
  localparam logic OP_RX_WORD  = 1'b0;
  localparam logic OP_TX_EMPTY = 1'b1;

  // Status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_ADDRESSED  = 3'd1;
  localparam logic [2:0] ST_SEND_START = 3'd2;
  localparam logic [2:0] ST_RECV_GOOD  = 3'd3;
  localparam logic [2:0] ST_RECV_BAD   = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_RECV = 4'b0100,
    PH_SEND = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [3:0] send_command_code;
    logic [3:0] receive_command_code;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [8:0] rx_word;
    logic       tx_complete;
    logic [7:0] fetched_byte;
  } in_item_t;

  typedef struct packed {
    logic             tx_valid;
    logic [8:0]       tx_word;
    logic             driver_enable;
    logic [2:0]       status_event;
    logic [3:0]       block_number;
    logic             mem_write;
    logic [CNT_W-1:0] mem_address;
    logic [7:0]       mem_data;
  } out_item_t;

endpackage

// ===== design/multidrop_serial_slave_transfer_core.sv =====
// Top level: slave side of a 9-bit multidrop serial link with header, send and receive.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------------------------
//  input   | in_valid, in_stall, in_item             | received words, tx events
//  result  | out_valid, out_stall, out_item          | tx words, memory, status
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// One item per cycle: each item is worked in a single pass of combinational logic
// into the result register, and its result shows the cycle after acceptance.
// in_stall is raised only while a held result is stalled on the output side.
// Synchronous active-low reset puts the link in idle with the driver off and the
// registers at their reset values; the header store is not reset.
module multidrop_serial_slave_transfer_core
  import mdst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      step_en;

  // Handshake: take an item whenever the result register is free or draining
  assign in_stall  = out_valid_r && out_stall;
  assign step_en   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address         <= NODE_ADDRESS_RST;
      cfg_r.send_command_code    <= SEND_CODE_RST;
      cfg_r.receive_command_code <= RECV_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_ADDRESS: cfg_r.node_address         <= cfg_data;
        CFG_SEND_CODE:    cfg_r.send_command_code    <= cfg_data[3:0];
        CFG_RECV_CODE:    cfg_r.receive_command_code <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mdst_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

endmodule

// ===== design/mdst_engine.sv =====
// Link state machine: phase, header store, counters and sum, one step per accepted item.
module mdst_engine
  import mdst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t           phase_r,  phase_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [7:0]       sum_r,    sum_nxt;
  logic [CNT_W-1:0] roff_r,   roff_nxt;
  logic             armed_r,  armed_nxt;
  logic             drv_r,    drv_nxt;
  logic [7:0]       hdr_r [HDR_BYTES];

  logic [7:0]       rx_byte;
  logic [7:0]       rx_sum;
  logic [3:0]       cmd;
  logic             hdr_we;
  logic [3:0]       blk_nxt;
  logic [CNT_W-1:0] hdr_addr;
  logic [CNT_W-1:0] hdr_len;

  assign rx_byte  = item.rx_word[7:0];
  assign rx_sum   = sum_r + rx_byte;
  assign cmd      = rx_byte[7:4];
  assign hdr_addr = {hdr_r[1], hdr_r[0]};
  assign hdr_len  = {hdr_r[3], hdr_r[2]};

  // Header bytes land while collecting the header
  assign hdr_we = step_en && (item.operation == OP_RX_WORD) && (phase_r == PH_HEAD)
                  && (cnt_r < CNT_W'(HDR_BYTES));

  // Block number as it stands after this step
  assign blk_nxt = (hdr_we && (cnt_r == CNT_W'(HDR_CMD))) ? rx_byte[3:0]
                                                          : hdr_r[HDR_CMD][3:0];

  // Next state and result of one item
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    roff_nxt  = roff_r;
    armed_nxt = armed_r;
    drv_nxt   = drv_r;
    result    = '0;

    if (item.operation == OP_RX_WORD) begin
      case (phase_r)
        PH_IDLE: begin
          if (item.rx_word == {1'b1, cfg.node_address}) begin
            result.status_event = ST_ADDRESSED;
            result.tx_valid     = 1'b1;
            result.tx_word      = item.rx_word;
            drv_nxt             = 1'b1;
            phase_nxt           = PH_HEAD;
            cnt_nxt             = '0;
            armed_nxt           = 1'b1;
            sum_nxt             = '0;
          end
        end
        PH_HEAD: begin
          sum_nxt = rx_sum;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(HDR_CMD)) begin
            drv_nxt = 1'b1;
            if (cmd == cfg.send_command_code) begin
              sum_nxt             = '0;
              roff_nxt            = hdr_addr;
              cnt_nxt             = hdr_len;
              phase_nxt           = PH_SEND;
              result.status_event = ST_SEND_START;
              armed_nxt           = 1'b1;
              result.tx_valid     = 1'b1;
              result.tx_word      = {1'b0, rx_sum};
            end else if (cmd == cfg.receive_command_code) begin
              sum_nxt         = '0;
              cnt_nxt         = '0;
              phase_nxt       = PH_RECV;
              armed_nxt       = 1'b1;
              result.tx_valid = 1'b1;
              result.tx_word  = {1'b0, rx_sum};
            end else begin
              // unknown command: drop the link
              phase_nxt = PH_IDLE;
              drv_nxt   = 1'b0;
            end
          end
        end
        PH_RECV: begin
          sum_nxt = rx_sum;
          if (cnt_r == hdr_len) begin
            // trailing byte: acknowledge with the sum
            result.status_event = (rx_sum == GOOD_SUM) ? ST_RECV_GOOD : ST_RECV_BAD;
            result.tx_valid     = 1'b1;
            result.tx_word      = {1'b0, rx_sum};
            drv_nxt             = 1'b1;
            cnt_nxt             = '0;
            armed_nxt           = 1'b1;
            phase_nxt           = PH_IDLE;
          end else begin
            result.mem_write   = 1'b1;
            result.mem_address = hdr_addr + cnt_r;
            result.mem_data    = rx_byte;
            cnt_nxt            = cnt_r + CNT_W'(1);
          end
        end
        default: ;  // words while sending are ignored
      endcase
    end else if (armed_r) begin
      if ((phase_r == PH_SEND) && (cnt_r != '0)) begin
        result.tx_valid = 1'b1;
        result.tx_word  = {1'b0, item.fetched_byte};
        sum_nxt         = sum_r + item.fetched_byte;
        roff_nxt        = roff_r + CNT_W'(1);
        cnt_nxt         = cnt_r - CNT_W'(1);
      end else if (item.tx_complete) begin
        armed_nxt = 1'b0;
        if (phase_r != PH_SEND) begin
          drv_nxt = 1'b0;
        end else begin
          // data streamed out: close with the data sum
          phase_nxt       = PH_IDLE;
          cnt_nxt         = '0;
          armed_nxt       = 1'b1;
          result.tx_valid = 1'b1;
          result.tx_word  = {1'b0, sum_r};
        end
      end
    end

    if (!result.mem_write) begin
      result.mem_address = roff_nxt;
    end
    result.driver_enable = drv_nxt;
    result.block_number  = blk_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      roff_r  <= '0;
      armed_r <= 1'b0;
      drv_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      roff_r  <= roff_nxt;
      armed_r <= armed_nxt;
      drv_r   <= drv_nxt;
    end
  end

  // Header store, no reset
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[cnt_r[HDR_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== design/mdst_checker.sv =====
// Checker: port-level assertions on the transfer core, bound to the top level.
module mdst_checker
  import mdst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Input back-pressure only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // Memory writes never coincide with a transmitted word
  a_write_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.mem_write |-> !out_item.tx_valid)
    else $error("memory write together with transmit");

  // Address bit only on the echo, which also turns the driver on
  a_addr_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.tx_word[8] |->
      out_item.tx_valid && out_item.driver_enable
      && (out_item.status_event == ST_ADDRESSED))
    else $error("address bit outside an address echo");

endmodule

bind multidrop_serial_slave_transfer_core mdst_checker u_checker (.*);
